>>> rtl/core/hhed_pkg.sv
// Shared types and constants for the hysteresis hold-time event detector.
package hhed_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int TIME_W    = 32;
  localparam int MARK_W    = 3;
  localparam int POLL_W    = 16;
  localparam int QDEPTH    = 4;
  localparam int PTR_W     = $clog2(QDEPTH);
  localparam int NUM_MS    = 3;

  // Item opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_THR_HIGH = 2'd0;
  localparam logic [1:0] REG_THR_LOW  = 2'd1;
  localparam logic [1:0] REG_POLL_MS  = 2'd2;

  localparam logic [SAMPLE_W-1:0] THR_RESET  = SAMPLE_W'(2000);
  localparam logic [POLL_W-1:0]   POLL_RESET = POLL_W'(200);

  // Hold-time milestones, ascending, and the mark each one raises
  localparam logic [TIME_W-1:0] MS_THR  [NUM_MS] = '{32'd1000, 32'd3000, 32'd5000};
  localparam logic [MARK_W-1:0] MS_MARK [NUM_MS] = '{3'd1, 3'd3, 3'd5};

  typedef struct packed {
    logic [MARK_W-1:0]   mark;
    logic [SAMPLE_W-1:0] smp;
    logic [TIME_W-1:0]   stamp;
  } hhed_event_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

>>> rtl/core/hysteresis_hold_event_detector_unit.sv
// Hysteresis comparator with hold-time milestone events and a small event ring.
//
// Input channel (in_valid/in_ready): one beat is either an ADC sample
// (in_op = sample) or a request to pop the oldest queued event (in_op = read).
// Result channel (out_valid/out_ready): exactly one beat per input beat, in
// order, carrying comparator state, hold time, milestone mask, last sample and,
// for a read, the popped event (all event fields zero otherwise).
// Configuration (cfg_we/cfg_index/cfg_data): thresholds and poll_ms; the user
// writes them only while idle, unenforced; a zero poll_ms is stored as 200.
//
// Results are registered: the comparator, saturating add, milestone compares and
// ring pointer update sit between the input ports and the result register.
// One beat is taken per cycle while in_ready is high. in_ready is high whenever
// the result register is empty or being drained, so a stalled receiver blocks
// input only while its pending result waits.
// Reset clears the comparator, hold time, flags, ring pointers and result
// valid; the ring slots themselves are not cleared (never read before written).
// The ring has four slots and keeps three events, dropping the oldest.
module hysteresis_hold_event_detector_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [hhed_pkg::SAMPLE_W-1:0]     in_sample,
  input  logic [hhed_pkg::TIME_W-1:0]       in_time_ms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_is_high,
  output logic [hhed_pkg::TIME_W-1:0]       out_hold_ms,
  output logic [hhed_pkg::NUM_MS-1:0]       out_fired_mask,
  output logic [hhed_pkg::SAMPLE_W-1:0]     out_last_sample,
  output logic                              out_event_valid,
  output logic [hhed_pkg::MARK_W-1:0]       out_event_mark,
  output logic [hhed_pkg::SAMPLE_W-1:0]     out_event_sample,
  output logic [hhed_pkg::TIME_W-1:0]       out_event_time,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [hhed_pkg::POLL_W-1:0]       cfg_data
);

  logic [hhed_pkg::SAMPLE_W-1:0] thr_high_r, thr_low_r;
  logic [hhed_pkg::POLL_W-1:0]   poll_ms_r;

  logic                          high_r, high_nxt;
  logic [hhed_pkg::TIME_W-1:0]   hold_r, hold_nxt;
  logic [hhed_pkg::NUM_MS-1:0]   flags_r, flags_nxt;
  logic [hhed_pkg::SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [hhed_pkg::PTR_W-1:0]    head_r, head_nxt, tail_r, tail_nxt;
  hhed_pkg::hhed_event_t         ring_r [hhed_pkg::QDEPTH];

  logic                          out_valid_r;
  logic                          o_high_r;
  logic [hhed_pkg::TIME_W-1:0]   o_hold_r;
  logic [hhed_pkg::NUM_MS-1:0]   o_flags_r;
  logic [hhed_pkg::SAMPLE_W-1:0] o_sample_r;
  hhed_pkg::hhed_event_t         o_event_r, pop_event;
  logic                          o_ev_valid_r, pop_valid;

  logic                          accept;
  logic                          cmp_high, toggled;
  logic [hhed_pkg::TIME_W-1:0]   base_hold;
  logic [hhed_pkg::NUM_MS-1:0]   base_flags, ev_en;
  logic [hhed_pkg::TIME_W:0]     hold_sum;
  logic [hhed_pkg::NUM_MS-1:0]   wr_en;
  logic [hhed_pkg::PTR_W-1:0]    wr_ptr [hhed_pkg::NUM_MS];
  hhed_pkg::hhed_event_t         wr_event [hhed_pkg::NUM_MS];

  assign in_ready = ~out_valid_r | out_ready;
  assign accept   = in_valid & in_ready;

  // Comparator and hold-time update for a sample beat
  always_comb begin
    cmp_high   = high_r ? (in_sample >= thr_low_r) : (in_sample > thr_high_r);
    toggled    = cmp_high != high_r;
    base_hold  = toggled ? '0 : hold_r;
    base_flags = toggled ? '0 : flags_r;
    hold_sum   = {1'b0, base_hold} + (hhed_pkg::TIME_W + 1)'(poll_ms_r);
  end

  always_comb begin
    logic [hhed_pkg::PTR_W-1:0] h, t, hn;
    h          = head_r;
    t          = tail_r;
    hn         = head_r;
    high_nxt   = high_r;
    hold_nxt   = hold_r;
    flags_nxt  = flags_r;
    sample_nxt = sample_r;
    ev_en      = '0;
    wr_en      = '0;
    pop_valid  = 1'b0;
    pop_event  = '0;
    for (int i = 0; i < hhed_pkg::NUM_MS; i++) begin
      wr_ptr[i]         = h;
      wr_event[i].mark  = hhed_pkg::MS_MARK[i];
      wr_event[i].smp   = in_sample;
      wr_event[i].stamp = in_time_ms;
    end
    if (in_op == hhed_pkg::OP_SAMPLE) begin
      sample_nxt = in_sample;
      high_nxt   = cmp_high;
      hold_nxt   = base_hold;
      if (cmp_high) begin
        hold_nxt = hold_sum[hhed_pkg::TIME_W] ? '1 : hold_sum[hhed_pkg::TIME_W-1:0];
      end
      for (int i = 0; i < hhed_pkg::NUM_MS; i++) begin
        ev_en[i] = cmp_high & ~base_flags[i] & (hold_nxt >= hhed_pkg::MS_THR[i]);
      end
      flags_nxt = base_flags | ev_en;
      // Events enter in ascending order; a full ring drops its oldest entry
      for (int i = 0; i < hhed_pkg::NUM_MS; i++) begin
        if (ev_en[i]) begin
          wr_en[i]  = 1'b1;
          wr_ptr[i] = h;
          hn        = hhed_pkg::ptr_inc(h);
          if (hn == t) begin
            t = hhed_pkg::ptr_inc(t);
          end
          h = hn;
        end
      end
    end else if (head_r != tail_r) begin
      pop_valid = 1'b1;
      pop_event = ring_r[tail_r];
      t         = hhed_pkg::ptr_inc(tail_r);
    end
    head_nxt = h;
    tail_nxt = t;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_high_r <= hhed_pkg::THR_RESET;
      thr_low_r  <= hhed_pkg::THR_RESET;
      poll_ms_r  <= hhed_pkg::POLL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hhed_pkg::REG_THR_HIGH: thr_high_r <= cfg_data[hhed_pkg::SAMPLE_W-1:0];
        hhed_pkg::REG_THR_LOW:  thr_low_r  <= cfg_data[hhed_pkg::SAMPLE_W-1:0];
        hhed_pkg::REG_POLL_MS:  poll_ms_r  <= (cfg_data == '0) ? hhed_pkg::POLL_RESET
                                                               : cfg_data;
        default: ;
      endcase
    end
  end

  // Detector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r   <= 1'b0;
      hold_r   <= '0;
      flags_r  <= '0;
      sample_r <= '0;
      head_r   <= '0;
      tail_r   <= '0;
    end else if (accept) begin
      high_r   <= high_nxt;
      hold_r   <= hold_nxt;
      flags_r  <= flags_nxt;
      sample_r <= sample_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
    end
  end

  // Event ring slots, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < hhed_pkg::NUM_MS; i++) begin
        if (wr_en[i]) begin
          ring_r[wr_ptr[i]] <= wr_event[i];
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      o_high_r     <= high_nxt;
      o_hold_r     <= hold_nxt;
      o_flags_r    <= flags_nxt;
      o_sample_r   <= sample_nxt;
      o_ev_valid_r <= pop_valid;
      o_event_r    <= pop_event;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_is_high      = o_high_r;
  assign out_hold_ms      = o_hold_r;
  assign out_fired_mask   = o_flags_r;
  assign out_last_sample  = o_sample_r;
  assign out_event_valid  = o_ev_valid_r;
  assign out_event_mark   = o_event_r.mark;
  assign out_event_sample = o_event_r.smp;
  assign out_event_time   = o_event_r.stamp;

  // While low the hold time and milestone mask are clear
  a_low_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_high |-> out_hold_ms == '0 && out_fired_mask == '0)
    else $error("hold state not cleared while low");

  // The first milestone flag tracks the hold time while high
  a_first_ms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_high |->
      out_fired_mask[0] == (out_hold_ms >= hhed_pkg::MS_THR[0]))
    else $error("first milestone flag out of step with hold time");

  // Milestones are raised in order
  a_ms_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_fired_mask[2] || out_fired_mask[1]) &&
                  (!out_fired_mask[1] || out_fired_mask[0]))
    else $error("milestone mask not cumulative");

  // An empty read beat carries a zero event
  a_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_event_valid |->
      out_event_mark == '0 && out_event_sample == '0 && out_event_time == '0)
    else $error("event fields set without a popped event");

endmodule
